### sv/wpng_pkg.sv
// Shared types and constants for the white/pink noise generator.
package wpng_pkg;

  localparam int unsigned LEVEL_W  = 17;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED        = 1'b1;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SLOW_POLE,
    MUL_SLOW_IN,
    MUL_MID_POLE,
    MUL_MID_IN,
    MUL_FAST_POLE,
    MUL_FAST_IN,
    MUL_MIX,
    MUL_PINK,
    MUL_LEVEL_HI,
    MUL_LEVEL_LO,
    MUL_CENTRE
  } mul_op_t;

  // What the accumulator does with last cycle's product.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_POLE,
    ACC_ADD_INPUT,
    ACC_LOAD_MIX,
    ACC_ADD_POLES,
    ACC_LOAD_LEVEL,
    ACC_ADD_LEVEL
  } acc_op_t;

  // Which result register takes a value this cycle.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_SLOW,
    WR_MID,
    WR_FAST,
    WR_NOISE,
    WR_SCALED,
    WR_OUT
  } wr_op_t;

  typedef struct packed {
    logic    start;
    mul_op_t mul;
    acc_op_t acc;
    wr_op_t  wr;
  } wpng_cmd_t;

  typedef struct packed {
    logic noise_color;
  } wpng_status_t;

  // One step of the 32-bit xorshift (13, 17, 5).
  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

### sv/wpng_ctrl.sv
// Sequencer for the noise datapath: steps the shared multiplier and output handshake.
module wpng_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  level_valid,
  output logic                  level_stall,
  output logic                  sample_valid,
  input  logic                  sample_stall,
  input  wpng_pkg::wpng_status_t status,
  output wpng_pkg::wpng_cmd_t    cmd
);
  import wpng_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SLOW_POLE,
    S_SLOW_IN,
    S_MID_POLE,
    S_MID_IN,
    S_FAST_POLE,
    S_FAST_IN,
    S_MIX,
    S_MIX_ROUND,
    S_SUM,
    S_PINK,
    S_PINK_ROUND,
    S_LEVEL_HI,
    S_LEVEL_LO,
    S_LEVEL_SUM,
    S_LEVEL_CLAMP,
    S_CENTRE,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign level_stall = (state != S_IDLE);
  assign accept      = level_valid && (state == S_IDLE);
  assign out_free    = !sample_valid || !sample_stall;

  always_comb begin
    cmd        = '{start: 1'b0, mul: MUL_NONE, acc: ACC_HOLD, wr: WR_NONE};
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.start = accept;
        if (accept) begin
          state_next = status.noise_color ? S_SLOW_POLE : S_LEVEL_HI;
        end
      end
      S_SLOW_POLE: begin
        cmd.mul    = MUL_SLOW_POLE;
        state_next = S_SLOW_IN;
      end
      S_SLOW_IN: begin
        cmd.mul    = MUL_SLOW_IN;
        cmd.acc    = ACC_LOAD_POLE;
        state_next = S_MID_POLE;
      end
      S_MID_POLE: begin
        cmd.mul    = MUL_MID_POLE;
        cmd.acc    = ACC_ADD_INPUT;
        state_next = S_MID_IN;
      end
      S_MID_IN: begin
        cmd.mul    = MUL_MID_IN;
        cmd.acc    = ACC_LOAD_POLE;
        cmd.wr     = WR_SLOW;
        state_next = S_FAST_POLE;
      end
      S_FAST_POLE: begin
        cmd.mul    = MUL_FAST_POLE;
        cmd.acc    = ACC_ADD_INPUT;
        state_next = S_FAST_IN;
      end
      S_FAST_IN: begin
        cmd.mul    = MUL_FAST_IN;
        cmd.acc    = ACC_LOAD_POLE;
        cmd.wr     = WR_MID;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mul    = MUL_MIX;
        cmd.acc    = ACC_ADD_INPUT;
        state_next = S_MIX_ROUND;
      end
      S_MIX_ROUND: begin
        cmd.acc    = ACC_LOAD_MIX;
        cmd.wr     = WR_FAST;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.acc    = ACC_ADD_POLES;
        state_next = S_PINK;
      end
      S_PINK: begin
        cmd.mul    = MUL_PINK;
        state_next = S_PINK_ROUND;
      end
      S_PINK_ROUND: begin
        cmd.wr     = WR_NOISE;
        state_next = S_LEVEL_HI;
      end
      S_LEVEL_HI: begin
        cmd.mul    = MUL_LEVEL_HI;
        state_next = S_LEVEL_LO;
      end
      S_LEVEL_LO: begin
        cmd.mul    = MUL_LEVEL_LO;
        cmd.acc    = ACC_LOAD_LEVEL;
        state_next = S_LEVEL_SUM;
      end
      S_LEVEL_SUM: begin
        cmd.acc    = ACC_ADD_LEVEL;
        state_next = S_LEVEL_CLAMP;
      end
      S_LEVEL_CLAMP: begin
        cmd.wr     = WR_SCALED;
        state_next = S_CENTRE;
      end
      S_CENTRE: begin
        cmd.mul    = MUL_CENTRE;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.wr     = WR_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        sample_valid <= 1'b1;
      end else if (!sample_stall) begin
        sample_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/wpng_datapath.sv
// Generator, pink filter state, shared multiplier, accumulator and output register.
module wpng_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wpng_pkg::wpng_cmd_t                  cmd,
  output wpng_pkg::wpng_status_t               status,
  input  logic [wpng_pkg::LEVEL_W-1:0]         noise_level,
  input  logic                                 cfg_write,
  input  logic [wpng_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wpng_pkg::CFG_W-1:0]           cfg_data,
  output logic signed [wpng_pkg::SAMPLE_W-1:0] noise_sample
);
  import wpng_pkg::*;

  // Coefficients, round(value * 2^30).
  localparam logic signed [31:0] COEF_SLOW_POLE = 32'sd1071218531;
  localparam logic signed [31:0] COEF_SLOW_IN   = 32'sd106349833;
  localparam logic signed [31:0] COEF_MID_POLE  = 32'sd1034013377;
  localparam logic signed [31:0] COEF_MID_IN    = 32'sd318382060;
  localparam logic signed [31:0] COEF_FAST_POLE = 32'sd612032840;
  localparam logic signed [31:0] COEF_FAST_IN   = 32'sd1130318677;
  localparam logic signed [31:0] COEF_WHITE_MIX = 32'sd198427489;
  localparam logic signed [31:0] COEF_PINK_GAIN = 32'sd214748365;
  localparam logic signed [31:0] COEF_CENTRE    = 32'sd759250124;

  localparam logic signed [63:0] HALF_30 = 64'sh0000_0000_2000_0000;
  localparam logic signed [63:0] HALF_37 = 64'sh0000_0010_0000_0000;
  localparam logic signed [63:0] HALF_23 = 64'sh0000_0000_0040_0000;
  localparam logic signed [63:0] HALF_16 = 64'sh0000_0000_0000_8000;
  localparam logic signed [63:0] HALF_38 = 64'sh0000_0020_0000_0000;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] MID_MAX = 64'sd8589934592;
  localparam logic signed [63:0] MID_MIN = -64'sd8589934592;
  localparam logic signed [63:0] OUT_MAX = 64'sd8388607;
  localparam logic signed [63:0] OUT_MIN = -64'sd8388608;

  function automatic logic signed [63:0] sext32(input logic signed [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic               noise_color;
  logic        [31:0] noise_register;
  logic signed [31:0] pink_slow;
  logic signed [31:0] pink_mid;
  logic signed [31:0] pink_fast;

  logic        [LEVEL_W-1:0]  level;
  logic signed [31:0]         white;
  logic signed [39:0]         noise;
  logic signed [34:0]         scaled;
  logic signed [63:0]         prod;
  logic signed [63:0]         acc;
  logic signed [63:0]         acc_next;
  logic signed [SAMPLE_W-1:0] sample;

  logic signed [35:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [67:0] mul_full;
  logic        [31:0] gen_next;
  logic signed [63:0] pole_shift;
  logic signed [63:0] pink_round;
  logic signed [63:0] level_shift;
  logic signed [63:0] out_round;

  assign status.noise_color = noise_color;
  assign noise_sample       = sample;
  assign gen_next           = xorshift32(noise_register);

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul)
      MUL_SLOW_POLE: begin
        mul_a = {{4{pink_slow[31]}}, pink_slow};
        mul_b = COEF_SLOW_POLE;
      end
      MUL_SLOW_IN: begin
        mul_a = {{4{white[31]}}, white};
        mul_b = COEF_SLOW_IN;
      end
      MUL_MID_POLE: begin
        mul_a = {{4{pink_mid[31]}}, pink_mid};
        mul_b = COEF_MID_POLE;
      end
      MUL_MID_IN: begin
        mul_a = {{4{white[31]}}, white};
        mul_b = COEF_MID_IN;
      end
      MUL_FAST_POLE: begin
        mul_a = {{4{pink_fast[31]}}, pink_fast};
        mul_b = COEF_FAST_POLE;
      end
      MUL_FAST_IN: begin
        mul_a = {{4{white[31]}}, white};
        mul_b = COEF_FAST_IN;
      end
      MUL_MIX: begin
        mul_a = {{4{white[31]}}, white};
        mul_b = COEF_WHITE_MIX;
      end
      MUL_PINK: begin
        mul_a = acc[35:0];
        mul_b = COEF_PINK_GAIN;
      end
      MUL_LEVEL_HI: begin
        mul_a = {{16{noise[39]}}, noise[39:20]};
        mul_b = {{(32-LEVEL_W){1'b0}}, level};
      end
      MUL_LEVEL_LO: begin
        mul_a = {16'b0, noise[19:0]};
        mul_b = {{(32-LEVEL_W){1'b0}}, level};
      end
      MUL_CENTRE: begin
        mul_a = {scaled[34], scaled};
        mul_b = COEF_CENTRE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_comb begin
    acc_next = acc;
    case (cmd.acc)
      ACC_LOAD_POLE:  acc_next = prod + HALF_30;
      ACC_ADD_INPUT:  acc_next = acc + (prod >>> 7);
      ACC_LOAD_MIX:   acc_next = (prod + HALF_37) >>> 37;
      ACC_ADD_POLES:  acc_next = acc + sext32(pink_slow) + sext32(pink_mid)
                                 + sext32(pink_fast);
      ACC_LOAD_LEVEL: acc_next = prod <<< 20;
      ACC_ADD_LEVEL:  acc_next = acc + prod + HALF_16;
      default:        acc_next = acc;
    endcase
  end

  assign pole_shift  = acc >>> 30;
  assign pink_round  = (prod + HALF_23) >>> 23;
  assign level_shift = acc >>> 16;
  assign out_round   = (prod + HALF_38) >>> 38;

  // Architectural state: generator, mode and pink filter poles.
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_color    <= 1'b0;
      noise_register <= 32'd1;
      pink_slow      <= '0;
      pink_mid       <= '0;
      pink_fast      <= '0;
    end else begin
      if (cmd.start) begin
        noise_register <= gen_next;
      end
      case (cmd.wr)
        WR_SLOW: pink_slow <= sat32(pole_shift);
        WR_MID:  pink_mid  <= sat32(pole_shift);
        WR_FAST: pink_fast <= sat32(pole_shift);
        default: ;
      endcase
      if (cfg_write) begin
        unique case (cfg_index)
          REG_NOISE_COLOR: noise_color <= cfg_data[0];
          REG_SEED:        noise_register <= (cfg_data == '0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Working registers of one transaction.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      level <= noise_level;
      white <= gen_next;
      noise <= {{8{gen_next[31]}}, gen_next};
    end
    if (cmd.mul != MUL_NONE) begin
      prod <= mul_full[63:0];
    end
    acc <= acc_next;
    case (cmd.wr)
      WR_NOISE: noise <= pink_round[39:0];
      WR_SCALED: begin
        if (level_shift > MID_MAX) begin
          scaled <= MID_MAX[34:0];
        end else if (level_shift < MID_MIN) begin
          scaled <= MID_MIN[34:0];
        end else begin
          scaled <= level_shift[34:0];
        end
      end
      WR_OUT: begin
        if (out_round > OUT_MAX) begin
          sample <= OUT_MAX[SAMPLE_W-1:0];
        end else if (out_round < OUT_MIN) begin
          sample <= OUT_MIN[SAMPLE_W-1:0];
        end else begin
          sample <= out_round[SAMPLE_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

### sv/white_pink_noise_generator.sv
// Top level of the white/pink noise generator: sequencer plus datapath.
//
// Usage:
//   Each transaction on the level channel (level_valid, level_stall,
//   noise_level) is one audio tick. The block advances a 32-bit xorshift
//   generator and returns one noise_sample transaction on the sample
//   channel (sample_valid, sample_stall).
//   Configuration: cfg_write with cfg_index 0 sets noise_color (0 white,
//   1 pink); cfg_index 1 reloads the generator from cfg_data (zero loads one).
//   Write configuration only while no tick is in flight.
//   Schedule: one shared 36x32 multiplier does every product in turn, so the
//   block holds level_stall and takes no new tick until it has returned
//   to idle. White mode runs only the level, centre and output steps; pink
//   mode runs the filter steps before them. The pink path spends three multiplies on
//   the pole updates' pole terms, three on their input terms, and two more
//   on the white mix and pink gain.
//   Stalls: the output register holds a finished sample while sample_stall
//   is high; the block still takes the next tick and parks at the final
//   step until the register frees up.
//   Reset: rst (synchronous) clears the pink filter state, selects white
//   mode and loads the generator with one. No clearing pass is needed.
module white_pink_noise_generator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 level_valid,
  output logic                                 level_stall,
  input  logic [wpng_pkg::LEVEL_W-1:0]         noise_level,
  output logic                                 sample_valid,
  input  logic                                 sample_stall,
  output logic signed [wpng_pkg::SAMPLE_W-1:0] noise_sample,
  input  logic                                 cfg_write,
  input  logic [wpng_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wpng_pkg::CFG_W-1:0]           cfg_data
);
  import wpng_pkg::*;

  wpng_cmd_t    cmd;
  wpng_status_t status;

  // Controller: walks the multiply/accumulate schedule per transaction.
  wpng_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .level_valid  (level_valid),
    .level_stall  (level_stall),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: generator, filter poles, shared multiplier, output register.
  wpng_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .noise_level  (noise_level),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .noise_sample (noise_sample)
  );

endmodule
